>>> rtl/core/esd_pkg.sv
// ----------------------------------------------------------------------------
// esd_pkg: escape sequence decoder shared definitions
// Status codes, the decoded-word type carried from front to back end, and
// the bundle written into the queue on each accepted character.
// ----------------------------------------------------------------------------
package esd_pkg;

	// Default run limit for \x escapes
	localparam int HEX_RUN_LIMIT_DEF = 32767;

	// Queue between front and back end; a power of two
	localparam int QDEPTH = 4;

	// Result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_ESC   = 3'd1;
	localparam logic [2:0] ST_SHORT_HEX = 3'd2;
	localparam logic [2:0] ST_NEWLINE   = 3'd3;
	localparam logic [2:0] ST_EOI       = 3'd4;

	// One decoded word: a byte, or the closing word of a literal
	typedef struct packed {
		logic [7:0] data;
		logic [2:0] status;
		logic       last;
		logic       is_char;
	} op_t;

	// Up to two words written into the queue in one cycle, in order
	typedef struct packed {
		logic [1:0] n;
		op_t        op0;
		op_t        op1;
	} push_t;

	function automatic op_t mk_op(input logic [7:0] data, input logic [2:0] status,
			input logic last, input logic is_char);
		op_t o;
		o.data    = data;
		o.status  = status;
		o.last    = last;
		o.is_char = is_char;
		return o;
	endfunction

endpackage

>>> rtl/core/esd_if.sv
// ----------------------------------------------------------------------------
// esd_if: escape sequence decoder channels
// Valid/ready channels for source characters and for decoded results.
// ----------------------------------------------------------------------------
interface esd_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       end_of_input;
	logic       char_literal;

	modport source(output valid, output ch, output end_of_input, output char_literal,
		input ready);
	modport sink(input valid, input ch, input end_of_input, input char_literal,
		output ready);
endinterface

interface esd_result_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic [63:0] packed_value;
	logic [2:0]  status;
	logic        last_of_literal;

	modport source(output valid, output data_byte, output packed_value, output status,
		output last_of_literal, input ready);
	modport sink(input valid, input data_byte, input packed_value, input status,
		input last_of_literal, output ready);
endinterface

>>> rtl/core/escape_sequence_decoder.sv
// Path: a character's words go into the queue, then to the output register;
// a non-digit that ends an escape run gives two results, unless it is a
// backslash. Throughput: one character per cycle while the queue has room
// for two words; results leave at one per cycle, while taken, through the
// single output register, so a queue of four words absorbs double results.
// Reset: arst_n clears scanner state, queue pointers, byte pack and output valid.
// ----------------------------------------------------------------------------
// escape_sequence_decoder: C string and character literal decoder
// Scanner front end, word queue and packing back end with output register.
// ----------------------------------------------------------------------------
module escape_sequence_decoder import esd_pkg::*; #(
	parameter int HEX_RUN_LIMIT = HEX_RUN_LIMIT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	esd_char_if.sink     chars,
	esd_result_if.source results
);
	// Words handed from the scanner to the queue
	push_t push;
	logic  space_ok;

	// Head of the queue toward the packer
	logic  pop_valid;
	op_t   pop_op;
	logic  pop_ready;

	// Scan characters; hold ready low while the queue lacks room for two words
	esd_front #(
		.HEX_RUN_LIMIT(HEX_RUN_LIMIT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.chars    (chars),
		.space_ok (space_ok),
		.push     (push)
	);

	// Decouple scanning from result delivery
	esd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.space_ok  (space_ok),
		.pop_valid (pop_valid),
		.pop_op    (pop_op),
		.pop_ready (pop_ready)
	);

	// Pack character literal bytes and drive the result channel
	esd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_op    (pop_op),
		.pop_ready (pop_ready),
		.results   (results)
	);
endmodule

>>> rtl/core/esd_front.sv
// ----------------------------------------------------------------------------
// esd_front: escape scanner
// Accepts one character per cycle while the queue has room, tracks escape and
// digit runs, and writes zero, one or two decoded words into the queue.
// ----------------------------------------------------------------------------
module esd_front import esd_pkg::*; #(
	parameter int HEX_RUN_LIMIT = HEX_RUN_LIMIT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	esd_char_if.sink     chars,
	input  logic         space_ok,
	output push_t        push
);
	localparam int CW0 = $clog2(HEX_RUN_LIMIT + 1);
	localparam int CW  = (CW0 > 4) ? CW0 : 4;

	localparam logic [1:0] MODE_PLAIN = 2'd0;
	localparam logic [1:0] MODE_ESC   = 2'd1;
	localparam logic [1:0] MODE_HEX   = 2'd2;
	localparam logic [1:0] MODE_OCT   = 2'd3;

	localparam logic [1:0] KIND_X   = 2'd0;
	localparam logic [1:0] KIND_U16 = 2'd1;
	localparam logic [1:0] KIND_U32 = 2'd2;
	localparam logic [1:0] KIND_OCT3 = 2'd0;
	localparam logic [1:0] KIND_OCT2 = 2'd1;

	logic [1:0]    mode_q, mode_d;
	logic [1:0]    kind_q, kind_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [7:0]    val_q, val_d;

	logic          acc;
	logic [7:0]    ch;
	logic          eoi, is_char;
	logic [7:0]    quote, lowc;

	op_t           p_op;
	logic          p_valid, p_esc;
	logic          hex_ok, oct_ok;
	logic [3:0]    hex_d;
	logic [CW-1:0] cnt_inc, lim, need;
	logic [7:0]    hex_val, oct_val;
	push_t         push_d;

	assign chars.ready = space_ok;
	assign acc         = chars.valid & chars.ready;
	assign ch          = chars.ch;
	assign eoi         = chars.end_of_input;
	assign is_char     = chars.char_literal;
	assign quote       = is_char ? 8'h27 : 8'h22;
	assign lowc        = ch | 8'h20;

	// Plain character handling, also used for run terminators
	always_comb begin
		p_op    = mk_op(ch, ST_OK, 1'b0, is_char);
		p_valid = 1'b1;
		p_esc   = 1'b0;
		if (eoi) begin
			p_op = mk_op(8'h00, ST_EOI, 1'b1, is_char);
		end else if (ch == 8'h0A) begin
			p_op = mk_op(8'h00, ST_NEWLINE, 1'b1, is_char);
		end else if (ch == quote) begin
			p_op = mk_op(8'h00, ST_OK, 1'b1, is_char);
		end else if (ch == 8'h5C) begin
			p_valid = 1'b0;
			p_esc   = 1'b1;
		end
	end

	// Digit classification
	always_comb begin
		hex_ok = 1'b0;
		hex_d  = 4'd0;
		if (!eoi && ch >= "0" && ch <= "9") begin
			hex_ok = 1'b1;
			hex_d  = ch[3:0];
		end else if (!eoi && lowc >= "a" && lowc <= "f") begin
			hex_ok = 1'b1;
			hex_d  = lowc[3:0] + 4'd9;
		end
		oct_ok  = !eoi && ch >= "0" && ch <= "7";
		hex_val = {val_q[3:0], hex_d};
		oct_val = {val_q[4:0], ch[2:0]};
		cnt_inc = cnt_q + CW'(1);
		case (kind_q)
			KIND_U32: begin
				lim  = CW'(8);
				need = CW'(8);
			end
			KIND_U16: begin
				lim  = CW'(4);
				need = CW'(4);
			end
			default: begin
				lim  = CW'(HEX_RUN_LIMIT);
				need = CW'(1);
			end
		endcase
	end

	always_comb begin
		mode_d = MODE_PLAIN;
		kind_d = 2'd0;
		cnt_d  = '0;
		val_d  = 8'h00;
		push_d = '0;
		case (mode_q)
			MODE_ESC: begin
				if (eoi) begin
					push_d.n   = 2'd1;
					push_d.op0 = mk_op(8'h00, ST_EOI, 1'b1, is_char);
				end else begin
					push_d.n = 2'd1;
					case (ch)
						"U": begin
							push_d.n = 2'd0;
							mode_d   = MODE_HEX;
							kind_d   = KIND_U32;
						end
						"u": begin
							push_d.n = 2'd0;
							mode_d   = MODE_HEX;
							kind_d   = KIND_U16;
						end
						"x": begin
							push_d.n = 2'd0;
							mode_d   = MODE_HEX;
							kind_d   = KIND_X;
						end
						"0", "1", "2", "3": begin
							push_d.n = 2'd0;
							mode_d   = MODE_OCT;
							kind_d   = KIND_OCT3;
							cnt_d    = CW'(1);
							val_d    = {5'd0, ch[2:0]};
						end
						"4", "5", "6", "7": begin
							push_d.n = 2'd0;
							mode_d   = MODE_OCT;
							kind_d   = KIND_OCT2;
							cnt_d    = CW'(1);
							val_d    = {5'd0, ch[2:0]};
						end
						8'h3F, 8'h5C, 8'h27, 8'h22: push_d.op0 = mk_op(ch, ST_OK, 1'b0, is_char);
						"a": push_d.op0 = mk_op(8'h07, ST_OK, 1'b0, is_char);
						"b": push_d.op0 = mk_op(8'h08, ST_OK, 1'b0, is_char);
						"f": push_d.op0 = mk_op(8'h0C, ST_OK, 1'b0, is_char);
						"n": push_d.op0 = mk_op(8'h0A, ST_OK, 1'b0, is_char);
						"r": push_d.op0 = mk_op(8'h0D, ST_OK, 1'b0, is_char);
						"t": push_d.op0 = mk_op(8'h09, ST_OK, 1'b0, is_char);
						"v": push_d.op0 = mk_op(8'h0B, ST_OK, 1'b0, is_char);
						default: push_d.op0 = mk_op(ch, ST_BAD_ESC, 1'b0, is_char);
					endcase
				end
			end
			MODE_HEX: begin
				if (hex_ok) begin
					if (cnt_inc >= lim) begin
						push_d.n   = 2'd1;
						push_d.op0 = mk_op(hex_val, ST_OK, 1'b0, is_char);
					end else begin
						mode_d = MODE_HEX;
						kind_d = kind_q;
						cnt_d  = cnt_inc;
						val_d  = hex_val;
					end
				end else begin
					// flush the partial value, then rescan the terminator
					push_d.op0 = mk_op(val_q, (cnt_q < need) ? ST_SHORT_HEX : ST_OK,
						1'b0, is_char);
					push_d.op1 = p_op;
					push_d.n   = p_valid ? 2'd2 : 2'd1;
					mode_d     = p_esc ? MODE_ESC : MODE_PLAIN;
				end
			end
			MODE_OCT: begin
				if (oct_ok) begin
					if (cnt_inc >= ((kind_q == KIND_OCT3) ? CW'(3) : CW'(2))) begin
						push_d.n   = 2'd1;
						push_d.op0 = mk_op(oct_val, ST_OK, 1'b0, is_char);
					end else begin
						mode_d = MODE_OCT;
						kind_d = kind_q;
						cnt_d  = cnt_inc;
						val_d  = oct_val;
					end
				end else begin
					push_d.op0 = mk_op(val_q, ST_OK, 1'b0, is_char);
					push_d.op1 = p_op;
					push_d.n   = p_valid ? 2'd2 : 2'd1;
					mode_d     = p_esc ? MODE_ESC : MODE_PLAIN;
				end
			end
			default: begin
				push_d.op0 = p_op;
				push_d.n   = p_valid ? 2'd1 : 2'd0;
				mode_d     = p_esc ? MODE_ESC : MODE_PLAIN;
			end
		endcase
	end

	always_comb begin
		push = push_d;
		if (!acc) begin
			push.n = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PLAIN;
			kind_q <= 2'd0;
			cnt_q  <= '0;
			val_q  <= 8'h00;
		end else if (acc) begin
			mode_q <= mode_d;
			kind_q <= kind_d;
			cnt_q  <= cnt_d;
			val_q  <= val_d;
		end
	end

`ifndef SYNTH
	// two words come only from a flushed run byte and its terminator
	a_two_words_start_with_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n == 2'd2) |-> (!push.op0.last && (mode_q == MODE_HEX || mode_q == MODE_OCT)))
		else $error("esd_front: two words without a pending run");
`endif
endmodule

>>> rtl/core/esd_queue.sv
// ----------------------------------------------------------------------------
// esd_queue: decoded word queue
// Short queue taking up to two words per cycle, giving one per cycle on pop.
// ----------------------------------------------------------------------------
module esd_queue import esd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	output logic  space_ok,
	output logic  pop_valid,
	output op_t   pop_op,
	input  logic  pop_ready
);
	localparam int PW = $clog2(QDEPTH);
	localparam int CW = $clog2(QDEPTH + 1);

	op_t           mem_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          pop;

	assign space_ok  = count_q <= CW'(QDEPTH - 2);
	assign pop_valid = count_q != '0;
	assign pop_op    = mem_q[rd_ptr_q];
	assign pop       = pop_valid & pop_ready;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.op0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_ptr_q + PW'(1)] <= push.op1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(push.n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			count_q <= count_q + CW'(push.n) - CW'(pop);
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0) |-> (count_q <= CW'(QDEPTH - 2)))
		else $error("esd_queue: write without room");
	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n == 2'd0 && !pop) |=> (count_q == $past(count_q)))
		else $error("esd_queue: count moved with no traffic");
`endif
endmodule

>>> rtl/core/esd_back.sv
// ----------------------------------------------------------------------------
// esd_back: result packer
// Drains the queue, packs character literal bytes, and holds each result
// in an output register until it is taken.
// ----------------------------------------------------------------------------
module esd_back import esd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pop_valid,
	input  op_t           pop_op,
	output logic          pop_ready,
	esd_result_if.source  results
);
	logic        out_valid_q;
	logic [7:0]  data_q;
	logic [63:0] packed_q;
	logic [2:0]  status_q;
	logic        last_q;
	logic [63:0] pack_q;
	logic        take;

	assign pop_ready = !out_valid_q || results.ready;
	assign take      = pop_valid && pop_ready;

	assign results.valid           = out_valid_q;
	assign results.data_byte       = data_q;
	assign results.packed_value    = packed_q;
	assign results.status          = status_q;
	assign results.last_of_literal = last_q;

	always_ff @(posedge clk) begin
		if (take) begin
			data_q   <= pop_op.last ? 8'h00 : pop_op.data;
			packed_q <= (pop_op.last && pop_op.is_char) ? pack_q : 64'd0;
			status_q <= pop_op.status;
			last_q   <= pop_op.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pack_q      <= 64'd0;
		end else begin
			if (take) begin
				out_valid_q <= 1'b1;
				pack_q      <= pop_op.last ? 64'd0 : {pack_q[55:0], pop_op.data};
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	a_pack_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(take && pop_op.last) |=> (pack_q == 64'd0))
		else $error("esd_back: pack not cleared after closing word");
`endif
endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: escape sequence decoder check
// Feeds literal characters through the valid/ready char channel and checks
// every decoded word on the result channel against a cycle-free predictor of
// the scanner. A short directed table comes first, then one long \x run that
// keeps only its low byte, then randomized literals. Both channels idle in
// random bursts.
// ----------------------------------------------------------------------------
module testbench;
	import esd_pkg::*;

	localparam int HEX_LIMIT       = HEX_RUN_LIMIT_DEF;
	localparam int LONG_HEX_DIGITS = 40;
	localparam int RANDOM_CHARS    = 1880;
	localparam int CALM_TAIL       = 250;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int SETTLE_CYCLES   = 16;

	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	// Hex run flavors and octal run lengths, held in the same kind field
	localparam logic [1:0] RUN_X     = 2'd0;
	localparam logic [1:0] RUN_U4    = 2'd1;
	localparam logic [1:0] RUN_U8    = 2'd2;
	localparam logic [1:0] OCT_THREE = 2'd0;
	localparam logic [1:0] OCT_TWO   = 2'd1;

	typedef enum logic [1:0] {SCAN_PLAIN, SCAN_ESC, SCAN_HEX, SCAN_OCT} scan_e;

	// One result word as the receiver sees it
	typedef struct packed {
		logic [7:0]  data;
		logic [63:0] pack;
		logic [2:0]  status;
		logic        last;
	} lit_word_t;

	// One row of the directed table; want is used only when typed is set
	typedef struct packed {
		logic [7:0] ch;
		logic       eoi;
		logic       is_char;
		logic       typed;
		lit_word_t  want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	esd_char_if   char_bus();
	esd_result_if result_bus();

	escape_sequence_decoder #(
		.HEX_RUN_LIMIT(HEX_LIMIT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.chars(char_bus),
		.results(result_bus)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Scanner predictor: its own copy of the decode state
	// ------------------------------------------------------------------------
	scan_e       scan_st    = SCAN_PLAIN;
	logic [1:0]  run_kind   = 2'd0;
	int unsigned run_digits = 0;
	logic [7:0]  run_value  = 8'd0;
	logic [63:0] byte_pack  = 64'd0;

	lit_word_t step_words[$];      // words caused by the current character
	lit_word_t expected_words[$];  // words still owed by the block, oldest first
	stim_row_t directed_rows[$];

	int   error_count = 0;
	int   chars_sent  = 0;
	logic idle_enable = 1'b1;
	logic tx_idle_on  = 1'b1;
	logic mode_noise  = 1'b0;
	logic use_typed   = 1'b0;
	lit_word_t typed_word;

	function automatic lit_word_t make_word(input logic [7:0] d, input logic [63:0] p,
			input logic [2:0] s, input logic l);
		lit_word_t w;
		w.data   = d;
		w.pack   = p;
		w.status = s;
		w.last   = l;
		return w;
	endfunction

	function automatic void clear_scan();
		scan_st    = SCAN_PLAIN;
		run_kind   = 2'd0;
		run_digits = 0;
		run_value  = 8'd0;
	endfunction

	// Emit a decoded byte and shift it into the char pack
	function automatic void put_byte(input logic [7:0] b, input logic [2:0] s);
		byte_pack = {byte_pack[55:0], b};
		clear_scan();
		step_words.push_back(make_word(b, 64'd0, s, 1'b0));
	endfunction

	// Closing word; pack is only reported in char mode
	function automatic void close_literal(input logic [2:0] s, input logic k);
		step_words.push_back(make_word(8'd0, k ? byte_pack : 64'd0, s, 1'b1));
		clear_scan();
		byte_pack = 64'd0;
	endfunction

	function automatic void start_run(input scan_e m, input logic [1:0] kind,
			input int unsigned n, input logic [7:0] v);
		scan_st    = m;
		run_kind   = kind;
		run_digits = n;
		run_value  = v;
	endfunction

	function automatic void plain_char(input logic [7:0] c, input logic e, input logic k);
		if (e) begin
			close_literal(ST_EOI, k);
		end else if (c == CH_NL) begin
			close_literal(ST_NEWLINE, k);
		end else if (c == (k ? CH_SQUOTE : CH_DQUOTE)) begin
			close_literal(ST_OK, k);
		end else if (c == CH_BSLASH) begin
			scan_st = SCAN_ESC;
		end else begin
			put_byte(c, ST_OK);
		end
	endfunction

	function automatic void escape_char(input logic [7:0] c, input logic e, input logic k);
		if (e) begin
			// dangling backslash is dropped
			close_literal(ST_EOI, k);
		end else if (c >= "0" && c <= "3") begin
			start_run(SCAN_OCT, OCT_THREE, 1, c - "0");
		end else if (c >= "4" && c <= "7") begin
			start_run(SCAN_OCT, OCT_TWO, 1, c - "0");
		end else begin
			case (c)
				"U": start_run(SCAN_HEX, RUN_U8, 0, 8'd0);
				"u": start_run(SCAN_HEX, RUN_U4, 0, 8'd0);
				"x": start_run(SCAN_HEX, RUN_X, 0, 8'd0);
				"?", CH_BSLASH, CH_SQUOTE, CH_DQUOTE: put_byte(c, ST_OK);
				"a": put_byte(8'h07, ST_OK);
				"b": put_byte(8'h08, ST_OK);
				"f": put_byte(8'h0C, ST_OK);
				"n": put_byte(8'h0A, ST_OK);
				"r": put_byte(8'h0D, ST_OK);
				"t": put_byte(8'h09, ST_OK);
				"v": put_byte(8'h0B, ST_OK);
				default: put_byte(c, ST_BAD_ESC);
			endcase
		end
	endfunction

	function automatic void hex_char(input logic [7:0] c, input logic e, input logic k);
		int unsigned limit;
		int unsigned need;
		logic [7:0]  low;
		logic [3:0]  d;
		limit = (run_kind == RUN_U8) ? 8 : (run_kind == RUN_U4) ? 4 : HEX_LIMIT;
		need  = (run_kind == RUN_U8) ? 8 : (run_kind == RUN_U4) ? 4 : 1;
		low   = c | 8'h20;
		if (!e && c >= "0" && c <= "9") begin
			d = 4'(c - "0");
		end else if (!e && low >= "a" && low <= "f") begin
			d = 4'(low - "a" + 8'd10);
		end else begin
			// run ended early: flush the partial value, then redo the terminator
			put_byte(run_value, (run_digits < need) ? ST_SHORT_HEX : ST_OK);
			plain_char(c, e, k);
			return;
		end
		run_value  = {run_value[3:0], d};
		run_digits = (run_digits + 1) & 32'h7FFF;
		if (run_digits >= limit)
			put_byte(run_value, ST_OK);
	endfunction

	function automatic void octal_char(input logic [7:0] c, input logic e, input logic k);
		int unsigned limit;
		limit = (run_kind == OCT_THREE) ? 3 : 2;
		if (e || c < "0" || c > "7") begin
			put_byte(run_value, ST_OK);
			plain_char(c, e, k);
			return;
		end
		run_value  = {run_value[4:0], c[2:0]};
		run_digits = (run_digits + 1) & 32'h7FFF;
		if (run_digits >= limit)
			put_byte(run_value, ST_OK);
	endfunction

	function automatic void decode_char(input logic [7:0] c, input logic e, input logic k);
		step_words.delete();
		case (scan_st)
			SCAN_ESC: escape_char(c, e, k);
			SCAN_HEX: hex_char(c, e, k);
			SCAN_OCT: octal_char(c, e, k);
			default:  plain_char(c, e, k);
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Directed table
	// ------------------------------------------------------------------------
	function automatic void add_row(input logic [7:0] c, input logic e, input logic k);
		stim_row_t r;
		r.ch      = c;
		r.eoi     = e;
		r.is_char = k;
		r.typed   = 1'b0;
		r.want    = make_word(8'd0, 64'd0, ST_OK, 1'b0);
		directed_rows.push_back(r);
	endfunction

	function automatic void add_row_want(input logic [7:0] c, input logic e, input logic k,
			input logic [7:0] d, input logic [63:0] p, input logic [2:0] s, input logic l);
		stim_row_t r;
		r.ch      = c;
		r.eoi     = e;
		r.is_char = k;
		r.typed   = 1'b1;
		r.want    = make_word(d, p, s, l);
		directed_rows.push_back(r);
	endfunction

	// ------------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------------

	// Drive one character, wait for the handshake, then log what it owes us.
	// In the random part the literal mode flips now and then for one character.
	task automatic send_char(input logic [7:0] c, input logic e, input logic k);
		logic kk;
		kk = (mode_noise && $urandom_range(0, 39) == 0) ? ~k : k;
		if (idle_enable && tx_idle_on && $urandom_range(0, 5) == 0) begin
			char_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		char_bus.valid        <= 1'b1;
		char_bus.ch           <= c;
		char_bus.end_of_input <= e;
		char_bus.char_literal <= kk;
		@(posedge clk);
		while (!char_bus.ready)
			@(posedge clk);
		decode_char(c, e, kk);
		if (use_typed) begin
			expected_words.push_back(typed_word);
		end else begin
			foreach (step_words[i])
				expected_words.push_back(step_words[i]);
		end
		chars_sent++;
	endtask

	// Drop valid and hold until every owed word has come back
	task automatic wait_results_drained();
		char_bus.valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] rand_hex_digit();
		int v;
		v = $urandom_range(0, 15);
		if (v < 10)
			return 8'("0" + v);
		return 8'(($urandom_range(0, 1) ? "A" : "a") + v - 10);
	endfunction

	// One piece of literal body: plain text, a stray byte or some escape
	task automatic send_part(input logic k);
		int         sel;
		int         n;
		logic [7:0] c;
		sel = $urandom_range(0, 9);
		case (sel)
			0, 1: begin
				c = 8'($urandom_range(8'h20, 8'h7E));
				if (c == CH_BSLASH || c == (k ? CH_SQUOTE : CH_DQUOTE))
					c = "z";
				send_char(c, 1'b0, k);
			end
			2: send_char(8'($urandom_range(0, 255)), 1'b0, k);
			3: begin
				send_char(CH_BSLASH, 1'b0, k);
				case ($urandom_range(0, 11))
					0: c = "?";
					1: c = CH_BSLASH;
					2: c = CH_SQUOTE;
					3: c = CH_DQUOTE;
					4: c = "a";
					5: c = "b";
					6: c = "f";
					7: c = "n";
					8: c = "r";
					9: c = "t";
					default: c = "v";
				endcase
				send_char(c, 1'b0, k);
			end
			4: begin
				// any byte after a backslash, unknown letters included
				send_char(CH_BSLASH, 1'b0, k);
				send_char(8'($urandom_range(0, 255)), 1'b0, k);
			end
			5, 6, 7: begin
				// hex escapes, mostly with the full digit count
				if (sel == 5) begin
					c = "x";
					n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 3);
				end else if (sel == 6) begin
					c = "u";
					n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 4;
				end else begin
					c = "U";
					n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : 8;
				end
				send_char(CH_BSLASH, 1'b0, k);
				send_char(c, 1'b0, k);
				repeat (n) send_char(rand_hex_digit(), 1'b0, k);
			end
			default: begin
				send_char(CH_BSLASH, 1'b0, k);
				send_char(8'("0" + $urandom_range(0, 7)), 1'b0, k);
				repeat ($urandom_range(0, 3))
					send_char(8'("0" + $urandom_range(0, 7)), 1'b0, k);
			end
		endcase
	endtask

	// A whole literal: body pieces, then usually the matching quote.
	// Long bodies push more than eight bytes through the char pack.
	task automatic send_literal();
		logic k;
		int   parts;
		k          = 1'($urandom_range(0, 1));
		tx_idle_on = $urandom_range(0, 3) != 0;
		parts = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 6);
		repeat (parts) send_part(k);
		case ($urandom_range(0, 11))
			0: send_char(8'($urandom_range(0, 255)), 1'b1, k);
			1: send_char(CH_NL, 1'b0, k);
			// stray byte: the literal may run on into the next one
			2: send_char(8'($urandom_range(0, 255)), 1'b0, k);
			default: send_char(k ? CH_SQUOTE : CH_DQUOTE, 1'b0, k);
		endcase
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		int   base;
		logic paused;
		arst_n                = 1'b0;
		char_bus.valid        = 1'b0;
		char_bus.ch           = 8'd0;
		char_bus.end_of_input = 1'b0;
		char_bus.char_literal = 1'b0;
		typed_word            = make_word(8'd0, 64'd0, ST_OK, 1'b0);

		// String literal: byte extremes, simple and bad escapes, short hex runs
		add_row_want("A", 1'b0, 1'b0, 8'h41, 64'd0, ST_OK, 1'b0);
		add_row_want(8'h00, 1'b0, 1'b0, 8'h00, 64'd0, ST_OK, 1'b0);
		add_row_want(8'hFF, 1'b0, 1'b0, 8'hFF, 64'd0, ST_OK, 1'b0);
		add_row(CH_BSLASH, 1'b0, 1'b0);
		add_row_want("n", 1'b0, 1'b0, CH_NL, 64'd0, ST_OK, 1'b0);
		// newline after a backslash is a bad escape and does not end the literal
		add_row(CH_BSLASH, 1'b0, 1'b0);
		add_row_want(CH_NL, 1'b0, 1'b0, CH_NL, 64'd0, ST_BAD_ESC, 1'b0);
		// \x with no digit at all, terminator redone as plain
		add_row(CH_BSLASH, 1'b0, 1'b0);
		add_row("x", 1'b0, 1'b0);
		add_row("G", 1'b0, 1'b0);
		// \u cut short by the closing quote: two words on one character
		add_row(CH_BSLASH, 1'b0, 1'b0);
		add_row("u", 1'b0, 1'b0);
		add_row("1", 1'b0, 1'b0);
		add_row("2", 1'b0, 1'b0);
		add_row(CH_DQUOTE, 1'b0, 1'b0);
		// Char literal: octal at its limit, octal ended early, packed close
		add_row(CH_BSLASH, 1'b0, 1'b1);
		add_row("3", 1'b0, 1'b1);
		add_row("7", 1'b0, 1'b1);
		add_row("7", 1'b0, 1'b1);
		add_row(CH_BSLASH, 1'b0, 1'b1);
		add_row("1", 1'b0, 1'b1);
		add_row("8", 1'b0, 1'b1);
		add_row(CH_SQUOTE, 1'b0, 1'b1);
		// Newline close, then a backslash left dangling at end of input
		add_row_want(CH_NL, 1'b0, 1'b0, 8'd0, 64'd0, ST_NEWLINE, 1'b1);
		add_row(CH_BSLASH, 1'b0, 1'b0);
		add_row_want(8'hFF, 1'b1, 1'b0, 8'd0, 64'd0, ST_EOI, 1'b1);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			use_typed  = directed_rows[i].typed;
			typed_word = directed_rows[i].want;
			send_char(directed_rows[i].ch, directed_rows[i].eoi, directed_rows[i].is_char);
		end
		use_typed = 1'b0;
		wait_results_drained();

		// One long \x run; only its low byte survives and the quote ends it
		tx_idle_on = 1'b0;
		send_char(CH_BSLASH, 1'b0, 1'b0);
		send_char("x", 1'b0, 1'b0);
		repeat (LONG_HEX_DIGITS) send_char(rand_hex_digit(), 1'b0, 1'b0);
		send_char("f", 1'b0, 1'b0);
		send_char(CH_DQUOTE, 1'b0, 1'b0);

		// Random literals; drain fully once and now and then, calm down at the end
		mode_noise = 1'b1;
		base       = chars_sent;
		paused     = 1'b0;
		while (chars_sent - base < RANDOM_CHARS) begin
			if (chars_sent - base > RANDOM_CHARS - CALM_TAIL)
				idle_enable = 1'b0;
			if ((!paused && chars_sent - base > RANDOM_CHARS / 3) ||
					$urandom_range(0, 99) == 0) begin
				wait_results_drained();
				paused = 1'b1;
			end
			send_literal();
		end

		wait_results_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Receiver: check each accepted word, then pick ready for the next cycle
	// ------------------------------------------------------------------------
	initial begin
		lit_word_t want;
		int        rx_stall;
		logic      rx_idle_on;
		result_bus.ready = 1'b0;
		rx_stall         = 0;
		rx_idle_on       = 1'b1;
		forever begin
			@(posedge clk);
			if (arst_n && result_bus.valid && result_bus.ready) begin
				if (expected_words.size() == 0) begin
					$error("unexpected word: data_byte %0h status %0d last_of_literal %0b",
						result_bus.data_byte, result_bus.status, result_bus.last_of_literal);
					error_count++;
				end else begin
					want = expected_words.pop_front();
					if (result_bus.data_byte !== want.data) begin
						$error("data_byte: expected %0h, actual %0h", want.data,
							result_bus.data_byte);
						error_count++;
					end
					if (result_bus.packed_value !== want.pack) begin
						$error("packed_value: expected %0h, actual %0h", want.pack,
							result_bus.packed_value);
						error_count++;
					end
					if (result_bus.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status,
							result_bus.status);
						error_count++;
					end
					if (result_bus.last_of_literal !== want.last) begin
						$error("last_of_literal: expected %0b, actual %0b", want.last,
							result_bus.last_of_literal);
						error_count++;
					end
				end
			end
			// switch stall behavior now and then so calm stretches occur too
			if ($urandom_range(0, 99) == 0)
				rx_idle_on = !rx_idle_on;
			if (rx_stall > 0) begin
				rx_stall--;
				result_bus.ready <= 1'b0;
			end else if (idle_enable && rx_idle_on && $urandom_range(0, 5) == 0) begin
				rx_stall = $urandom_range(1, 13) - 1;
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: too many cycles with no word moving on either channel
	// ------------------------------------------------------------------------
	initial begin
		int stuck_cycles;
		stuck_cycles = 0;
		while (stuck_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((char_bus.valid && char_bus.ready) || (result_bus.valid && result_bus.ready))
				stuck_cycles = 0;
			else
				stuck_cycles++;
		end
		$display("*** FAILED ***");
		$finish;
	end

endmodule
